// ===== sv/dq_pkg.sv =====
package dq_pkg;

    localparam int DEPTH_DEFAULT      = 16;
    localparam int DATA_WIDTH_DEFAULT = 32;

    localparam int ACTION_W    = 3;
    localparam int DATUM_W     = 32;
    localparam int POSITION_W  = 5;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int OCCUPANCY_W = 5;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_READ       = 3'd4,
        ACT_WRITE      = 3'd5,
        ACT_CLEAR      = 3'd6
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef struct packed {
        logic take;
        logic load;
    } dq_cmd_t;

endpackage

// ===== sv/double_ended_queue.sv =====
// Double-ended queue over a ring buffer of DEPTH entries.
// Slave channel (s_*): one beat is one action: push front or back, pop front
// or back, read or write at a signed position (negative counts from the
// tail), or clear. Master channel (m_*): exactly one result beat per action,
// carrying the popped or read entry (zero otherwise), a status code and the
// occupancy after the action.
// The result is registered: the entry store has a registered read port, so
// the entry is fetched as the action beat is taken and the result register
// is loaded from it in the response state, once any earlier result is taken.
// The controller's accept/respond sequence takes a new action only after the
// last result is loaded. s_tready is high while the controller waits for an
// action, including while a result sits unread.
// Reset: queue empty, front pointer zero, no result pending; entry contents
// are left as they are and never read before being written.
// Receiver stall: the result register holds its beat; one further action can
// be taken, after which s_tready stays low until the held beat is taken.
module double_ended_queue #(
    parameter int DEPTH      = dq_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [dq_pkg::S_TDATA_W-1:0] s_tdata,  // action[2:0], datum[34:3], position[39:35]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [dq_pkg::M_TDATA_W-1:0] m_tdata   // value[31:0], status[33:32], occupancy[38:34]
);

    import dq_pkg::*;

    dq_cmd_t                cmd;
    action_t                action;
    logic [DATUM_W-1:0]     datum;
    logic [POSITION_W-1:0]  position;
    logic [VALUE_W-1:0]     value;
    status_t                status;
    logic [OCCUPANCY_W-1:0] occupancy;

    assign action   = action_t'(s_tdata[ACTION_W-1:0]);
    assign datum    = s_tdata[ACTION_W +: DATUM_W];
    assign position = s_tdata[ACTION_W + DATUM_W +: POSITION_W];

    dq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    dq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .action    (action),
        .datum     (datum),
        .position  (position),
        .value     (value),
        .status    (status),
        .occupancy (occupancy)
    );

    assign m_tdata = {1'b0, occupancy, status, value};

endmodule

// ===== sv/dq_ram.sv =====
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/dq_ctrl.sv =====
module dq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    output dq_pkg::dq_cmd_t cmd
);

    import dq_pkg::*;

    typedef enum logic {
        IDLE,
        RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   load;

    assign s_tready = (state_reg == IDLE);
    assign load     = (state_reg == RESP) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = RESP;
                end
            end
            RESP:
            begin
                if (load)
                begin
                    state_next    = IDLE;
                    m_tvalid_next = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign cmd.take = s_tvalid && s_tready;
    assign cmd.load = load;

    a_load_only_in_resp: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (state_reg == RESP))
        else $error("load outside response state");

    a_take_leads_to_resp: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |=> (state_reg == RESP))
        else $error("accepted beat did not enter response state");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> m_tvalid_reg)
        else $error("result load did not raise m_tvalid");

endmodule

// ===== sv/dq_datapath.sv =====
module dq_datapath #(
    parameter int DEPTH      = dq_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  dq_pkg::dq_cmd_t                cmd,
    input  dq_pkg::action_t                action,
    input  logic [dq_pkg::DATUM_W-1:0]     datum,
    input  logic [dq_pkg::POSITION_W-1:0]  position,
    output logic [dq_pkg::VALUE_W-1:0]     value,
    output dq_pkg::status_t                status,
    output logic [dq_pkg::OCCUPANCY_W-1:0] occupancy
);

    import dq_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = ((CW > 6) ? CW : 6) + 1;

    logic [PW-1:0] front_reg;
    logic [PW-1:0] front_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    status_t                pend_status_reg;
    status_t                pend_status_next;
    logic                   pend_read_reg;
    logic                   pend_read_next;
    logic [OCCUPANCY_W-1:0] pend_occ_reg;

    logic [VALUE_W-1:0]     value_reg;
    status_t                status_reg;
    logic [OCCUPANCY_W-1:0] occ_reg;

    logic          full;
    logic          empty;
    logic [PW-1:0] front_inc;
    logic [PW-1:0] front_dec;
    logic [PW-1:0] offset;
    logic [PW:0]   slot_sum;
    logic [PW-1:0] slot;

    logic [5:0]    back6;
    logic [EW-1:0] count_e;
    logic [EW-1:0] back_e;
    logic [EW-1:0] fwd_e;
    logic          in_range;
    logic [EW-1:0] index_e;

    logic                  we;
    logic                  re;
    logic [PW-1:0]         waddr;
    logic [63:0]           datum_wide;
    logic [DATA_WIDTH-1:0] wdata;
    logic [DATA_WIDTH-1:0] rdata;
    logic [63:0]           rdata_wide;

    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign front_inc = (front_reg == PW'(DEPTH - 1)) ? '0 : front_reg + PW'(1);
    assign front_dec = (front_reg == '0) ? PW'(DEPTH - 1) : front_reg - PW'(1);

    assign back6    = 6'd32 - {1'b0, position};
    assign count_e  = EW'(count_reg);
    assign back_e   = EW'(back6);
    assign fwd_e    = EW'(position[POSITION_W-2:0]);
    assign in_range = position[POSITION_W-1] ? (back_e <= count_e) : (fwd_e < count_e);
    assign index_e  = position[POSITION_W-1] ? (count_e - back_e) : fwd_e;

    always_comb
    begin
        unique case (action)
            ACT_POP_FRONT: offset = '0;
            ACT_PUSH_BACK: offset = count_reg[PW-1:0];
            ACT_POP_BACK:  offset = PW'(count_reg - CW'(1));
            default:       offset = index_e[PW-1:0];
        endcase
    end

    assign slot_sum = {1'b0, front_reg} + {1'b0, offset};
    assign slot     = (slot_sum >= (PW+1)'(DEPTH)) ? PW'(slot_sum - (PW+1)'(DEPTH))
                                                   : slot_sum[PW-1:0];

    always_comb
    begin
        front_next       = front_reg;
        count_next       = count_reg;
        pend_status_next = ST_OK;
        pend_read_next   = 1'b0;
        we               = 1'b0;
        re               = 1'b0;
        waddr            = slot;
        unique case (action)
            ACT_PUSH_FRONT:
            begin
                if (full)
                begin
                    pend_status_next = ST_FULL;
                end
                else
                begin
                    front_next = front_dec;
                    count_next = count_reg + CW'(1);
                    waddr      = front_dec;
                    we         = 1'b1;
                end
            end
            ACT_PUSH_BACK:
            begin
                if (full)
                begin
                    pend_status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                    we         = 1'b1;
                end
            end
            ACT_POP_FRONT:
            begin
                if (empty)
                begin
                    pend_status_next = ST_EMPTY;
                end
                else
                begin
                    front_next     = front_inc;
                    count_next     = count_reg - CW'(1);
                    re             = 1'b1;
                    pend_read_next = 1'b1;
                end
            end
            ACT_POP_BACK:
            begin
                if (empty)
                begin
                    pend_status_next = ST_EMPTY;
                end
                else
                begin
                    count_next     = count_reg - CW'(1);
                    re             = 1'b1;
                    pend_read_next = 1'b1;
                end
            end
            ACT_READ:
            begin
                if (in_range)
                begin
                    re             = 1'b1;
                    pend_read_next = 1'b1;
                end
                else
                begin
                    pend_status_next = ST_RANGE;
                end
            end
            ACT_WRITE:
            begin
                if (in_range)
                begin
                    we = 1'b1;
                end
                else
                begin
                    pend_status_next = ST_RANGE;
                end
            end
            ACT_CLEAR:
            begin
                front_next = '0;
                count_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    assign datum_wide = 64'(datum);
    assign wdata      = datum_wide[DATA_WIDTH-1:0];

    dq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.take && we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.take && re),
        .raddr (slot),
        .rdata (rdata)
    );

    assign rdata_wide = 64'(rdata);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else if (cmd.take)
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            pend_status_reg <= pend_status_next;
            pend_read_reg   <= pend_read_next;
            pend_occ_reg    <= OCCUPANCY_W'(count_next);
        end
        if (cmd.load)
        begin
            value_reg  <= pend_read_reg ? rdata_wide[VALUE_W-1:0] : '0;
            status_reg <= pend_status_reg;
            occ_reg    <= pend_occ_reg;
        end
    end

    assign value     = value_reg;
    assign status    = status_reg;
    assign occupancy = occ_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
        front_reg < PW'(DEPTH - 1) || front_reg == PW'(DEPTH - 1))
        else $error("front pointer outside ring");

    a_full_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take && full && (action == ACT_PUSH_FRONT || action == ACT_PUSH_BACK)
        |=> $stable(count_reg) && $stable(front_reg))
        else $error("push on full queue changed state");

    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take && !empty && (action == ACT_POP_FRONT || action == ACT_POP_BACK)
        |=> count_reg == $past(count_reg) - CW'(1))
        else $error("pop did not shrink queue by one");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import dq_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;
    localparam int RANDOM_ACTIONS = 400;
    localparam int QUIET_FROM     = 340;
    localparam int PAUSE_AT       = 200;

    typedef struct packed {
        logic [VALUE_W-1:0]     value;
        status_t                status;
        logic [OCCUPANCY_W-1:0] occupancy;
    } deque_result_t;

    typedef struct {
        logic [ACTION_W-1:0]   act;
        logic [DATUM_W-1:0]    dat;
        logic [POSITION_W-1:0] pos;
        int                    reps;
        bit                    typed;
        deque_result_t         res;
    } script_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // action[2:0], datum[34:3], position[39:35]
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // value[31:0], status[33:32], occupancy[38:34]

    logic [DATUM_W-1:0]     ring [DEPTH_DEFAULT];
    logic [3:0]             head_slot;
    logic [OCCUPANCY_W-1:0] fill_count;

    deque_result_t results_due [$];
    int            mismatches;
    int            actions_sent;
    int            results_checked;
    int            status_hits [4];
    bit            quiet;

    script_row_t script [0:19] = '{
        '{ACT_POP_FRONT,  32'h0000_0000, 5'h00, 1,  1'b1, '{32'd0, ST_EMPTY, 5'd0}},
        '{ACT_POP_BACK,   32'h0000_0000, 5'h00, 1,  1'b1, '{32'd0, ST_EMPTY, 5'd0}},
        '{ACT_READ,       32'h0000_0000, 5'h00, 1,  1'b1, '{32'd0, ST_RANGE, 5'd0}},
        '{ACT_WRITE,      32'h1234_5678, 5'h1f, 1,  1'b1, '{32'd0, ST_RANGE, 5'd0}},
        '{ACT_PUSH_BACK,  32'hffff_ffff, 5'h00, 1,  1'b1, '{32'd0, ST_OK,    5'd1}},
        '{ACT_PUSH_FRONT, 32'h0000_0000, 5'h00, 1,  1'b1, '{32'd0, ST_OK,    5'd2}},
        '{ACT_READ,       32'h0000_0000, 5'h1f, 1,  1'b0, '{32'd0, ST_OK,    5'd0}},
        '{ACT_READ,       32'h0000_0000, 5'h1d, 1,  1'b0, '{32'd0, ST_OK,    5'd0}},
        '{ACT_WRITE,      32'ha5a5_5a5a, 5'h01, 1,  1'b0, '{32'd0, ST_OK,    5'd0}},
        '{ACT_UNUSED,     32'hdead_beef, 5'h10, 1,  1'b0, '{32'd0, ST_OK,    5'd0}},
        '{ACT_POP_BACK,   32'h0000_0000, 5'h00, 1,  1'b0, '{32'd0, ST_OK,    5'd0}},
        '{ACT_CLEAR,      32'h0000_0000, 5'h00, 1,  1'b1, '{32'd0, ST_OK,    5'd0}},
        '{ACT_PUSH_FRONT, 32'h8000_0001, 5'h00, 16, 1'b0, '{32'd0, ST_OK,    5'd0}},
        '{ACT_PUSH_BACK,  32'h5555_5555, 5'h00, 1,  1'b1, '{32'd0, ST_FULL,  5'd16}},
        '{ACT_PUSH_FRONT, 32'haaaa_aaaa, 5'h00, 1,  1'b1, '{32'd0, ST_FULL,  5'd16}},
        '{ACT_READ,       32'h0000_0000, 5'h0f, 1,  1'b0, '{32'd0, ST_OK,    5'd0}},
        '{ACT_READ,       32'h0000_0000, 5'h10, 1,  1'b0, '{32'd0, ST_OK,    5'd0}},
        '{ACT_WRITE,      32'h0000_0000, 5'h10, 1,  1'b0, '{32'd0, ST_OK,    5'd0}},
        '{ACT_POP_FRONT,  32'h0000_0000, 5'h00, 1,  1'b0, '{32'd0, ST_OK,    5'd0}},
        '{ACT_CLEAR,      32'h0000_0000, 5'h00, 1,  1'b1, '{32'd0, ST_OK,    5'd0}}
    };

    double_ended_queue u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL double_ended_queue");
        $finish;
    end

    task automatic apply_action(input logic [ACTION_W-1:0] act, input logic [DATUM_W-1:0] dat,
                                input logic [POSITION_W-1:0] pos, output deque_result_t res);
        int   p;
        int   cnt;
        int   off;
        bit   hit;
        logic [3:0] slot;
        res = '{32'd0, ST_OK, 5'd0};
        p = $signed(pos);
        cnt = fill_count;
        hit = (p >= 0) ? (p < cnt) : (-p <= cnt);
        off = (p >= 0) ? p : cnt + p;
        case (act)
            ACT_PUSH_FRONT, ACT_PUSH_BACK:
            begin
                if (cnt >= DEPTH_DEFAULT)
                    res.status = ST_FULL;
                else if (act == ACT_PUSH_FRONT)
                begin
                    head_slot = head_slot - 4'd1;
                    ring[head_slot] = dat;
                    fill_count = fill_count + 5'd1;
                end
                else
                begin
                    slot = head_slot + fill_count[3:0];
                    ring[slot] = dat;
                    fill_count = fill_count + 5'd1;
                end
            end
            ACT_POP_FRONT:
            begin
                if (cnt == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    res.value = ring[head_slot];
                    head_slot = head_slot + 4'd1;
                    fill_count = fill_count - 5'd1;
                end
            end
            ACT_POP_BACK:
            begin
                if (cnt == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    slot = head_slot + fill_count[3:0] - 4'd1;
                    res.value = ring[slot];
                    fill_count = fill_count - 5'd1;
                end
            end
            ACT_READ, ACT_WRITE:
            begin
                slot = head_slot + off[3:0];
                if (!hit)
                    res.status = ST_RANGE;
                else if (act == ACT_READ)
                    res.value = ring[slot];
                else
                    ring[slot] = dat;
            end
            ACT_CLEAR:
            begin
                fill_count = 5'd0;
                head_slot = 4'd0;
            end
            default:
            begin
            end
        endcase
        res.occupancy = fill_count;
    endtask

    task automatic offer(input logic [ACTION_W-1:0] act, input logic [DATUM_W-1:0] dat,
                         input logic [POSITION_W-1:0] pos, input bit typed,
                         input deque_result_t typed_res);
        deque_result_t predicted;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {pos, dat, act};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        apply_action(act, dat, pos, predicted);
        results_due = {results_due, (typed ? typed_res : predicted)};
        actions_sent++;
    endtask

    task automatic hold_sender(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
    endtask

    function automatic logic [ACTION_W-1:0] pick_action(input int mode);
        int r;
        int push_top;
        int pop_top;
        r = $urandom_range(0, 99);
        push_top = (mode == 0) ? 60 : (mode == 1) ? 25 : 35;
        pop_top  = (mode == 0) ? 75 : (mode == 1) ? 70 : 60;
        if (r < 2)
            return ACT_CLEAR;
        if (r < 4)
            return ACT_UNUSED;
        if (r < push_top)
            return $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
        if (r < pop_top)
            return $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
        if (r < 88)
            return ACT_READ;
        return ACT_WRITE;
    endfunction

    initial
    begin
        int left;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (quiet || $urandom_range(0, 4) != 0)
            begin
                m_tready <= 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0)
                begin
                    left = $urandom_range(20, 80);
                    repeat (left) @(negedge clk);
                end
            end
            else
            begin
                m_tready <= 1'b0;
                left = $urandom_range(1, 18);
                repeat (left - 1) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        deque_result_t got;
        deque_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.value     = m_tdata[31:0];
            got.status    = status_t'(m_tdata[33:32]);
            got.occupancy = m_tdata[38:34];
            if (results_due.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual %h", $time, got);
                mismatches++;
            end
            else
            begin
                want = results_due[0];
                results_due.delete(0);
                results_checked++;
                status_hits[want.status]++;
                if (got.value !== want.value)
                begin
                    $display("%0t value: expected %h, actual %h", $time, want.value, got.value);
                    mismatches++;
                end
                if (got.status !== want.status)
                begin
                    $display("%0t status: expected %0d, actual %0d", $time, want.status,
                             got.status);
                    mismatches++;
                end
                if (got.occupancy !== want.occupancy)
                begin
                    $display("%0t occupancy: expected %0d, actual %0d", $time,
                             want.occupancy, got.occupancy);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        logic [ACTION_W-1:0]   act;
        logic [DATUM_W-1:0]    dat;
        logic [POSITION_W-1:0] pos;
        int                    mode;
        int                    mode_left;
        int                    gap_odds;
        int                    k;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        quiet      = 1'b0;
        head_slot  = 4'd0;
        fill_count = 5'd0;
        mismatches = 0;
        mode       = 0;
        mode_left  = 0;
        gap_odds   = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
            for (int j = 0; j < script[i].reps; j++)
                offer(script[i].act, script[i].dat + DATUM_W'(j), script[i].pos,
                      script[i].typed, script[i].res);

        for (int n = 0; n < RANDOM_ACTIONS; n++)
        begin
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(10, 40);
                gap_odds = $urandom_range(0, 3);
            end
            mode_left--;
            quiet = (n >= QUIET_FROM);
            if (n == PAUSE_AT)
            begin
                hold_sender(1);
                while (results_due.size() != 0)
                    @(posedge clk);
            end
            if (!quiet && gap_odds != 0 && $urandom_range(0, 3) < gap_odds)
                hold_sender($urandom_range(1, 18));

            act = pick_action(mode);
            case ($urandom_range(0, 7))
                0: dat = '0;
                1: dat = '1;
                default: dat = $urandom;
            endcase
            if (fill_count != 0 && $urandom_range(0, 9) < 8)
            begin
                k = $urandom_range(0, fill_count - 1);
                pos = $urandom_range(0, 1) ? POSITION_W'(k) : POSITION_W'(k - fill_count);
            end
            else
                pos = POSITION_W'($urandom);
            offer(act, dat, pos, 1'b0, '{32'd0, ST_OK, 5'd0});
        end

        hold_sender(1);
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Ran %0d actions, %0d results checked", actions_sent, results_checked);
        $display("Status mix: %0d ok, %0d empty pops, %0d out of range, %0d full pushes",
                 status_hits[ST_OK], status_hits[ST_EMPTY], status_hits[ST_RANGE],
                 status_hits[ST_FULL]);
        if (mismatches == 0)
            $display("PASS double_ended_queue");
        else
            $display("FAIL double_ended_queue");
        $finish;
    end

endmodule
